// ===== hw/rtl/four_level_page_table_walker_assert.svh =====
// Assertion macros for the four-level page table walker.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define PTW_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error("page table walker check failed");

// Check that a condition implies a consequence in the next cycle.
`define PTW_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error("page table walker check failed");

`endif

// ===== hw/rtl/ptw_pkg.sv =====
// Shared types, constants and helpers for the four-level page table walker.
// No dependencies.
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int VA_W       = 48;
    localparam int DATA_W     = 64;
    localparam int PA_W       = 52;
    localparam int FRAME_W    = 40;
    localparam int IDX_W      = 9;
    localparam int LVL_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int PAGE_OFS_W = 12;
    localparam int BIG_OFS_W  = 21;
    localparam int ENTRY_SH_W = 3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;

    // Register select: byte address bit 3 picks the 8-byte register slot
    localparam logic REG_TOP_FRAME = 1'b0;

    // Walk levels
    localparam logic [LVL_W-1:0] LVL_IDLE = 3'd0;
    localparam logic [LVL_W-1:0] LVL_PT   = 3'd1;
    localparam logic [LVL_W-1:0] LVL_PD   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_PDPT = 3'd3;
    localparam logic [LVL_W-1:0] LVL_PML4 = 3'd4;

    // Input kinds
    localparam logic KIND_REQUEST  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    // Result kinds
    localparam logic RES_READ = 1'b0;
    localparam logic RES_DONE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK_4K        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK_2M        = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_PRESENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED  = 2'd3;

    // Entry bit positions
    localparam int ENTRY_PRESENT_BIT = 0;
    localparam int ENTRY_PS_BIT      = 7;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [VA_W-1:0]  vaddr;
    } t_walk_state;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [PA_W-1:0]     addr;
        logic [STATUS_W-1:0] status;
    } t_step_res;

    // Pick the 9-bit table index of a virtual address for a walk level
    function automatic logic [IDX_W-1:0] level_index(
        input logic [VA_W-1:0]  va,
        input logic [LVL_W-1:0] lvl
    );
        logic [IDX_W-1:0] idx;
        idx = '0;
        case (lvl)
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            LVL_PT:   idx = va[20:12];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

endpackage

// ===== hw/rtl/four_level_page_table_walker.sv =====
// Four-level x86-64 page table walker top level: input register, step logic,
// result register, APB config. Depends on ptw_pkg, ptw_cfg_regs, ptw_next_step.
//
// Usage:
//   Slave stream (s_axis_*): tuser = kind (0 request, 1 read response);
//   tdata = req_va for a request, mem_data for a response.
//   Master stream (m_axis_*): tuser = result_kind (0 read request for an
//   entry, 1 translation finished); tdata = phys_addr and status.
//   A request answers with a read of the PML4 entry; each response answers
//   with the next entry read or the final result. A response while no walk is
//   running produces nothing. A request during a walk restarts the walk.
//   APB: one 64-bit register at byte address 0, the top-level table frame;
//   write it only while the walker is idle.
// Pipeline:
//   An accepted item passes the input register, then the result register,
//   to master valid; one item per cycle while m_axis_tready is high. The walk
//   state register is updated as each item leaves the input register.
// Reset: clears the frame register, the walk state and both valid flags.
// Stall: while m_axis_tready is low the result holds; one more item may wait
//   in the input register, after which s_axis_tready drops.
`timescale 1ns / 1ps
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Slave stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [111:0]                   s_axis_tdata,  // [47:0] req_va, [111:48] mem_data
    input  logic                           s_axis_tuser,  // [0] kind
    // Master stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [55:0]                    m_axis_tdata,  // [51:0] phys_addr, [53:52] status, zero pad
    output logic                           m_axis_tuser,  // [0] result_kind
    // APB config
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ptw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ptw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ptw_pkg::*;

    logic [FRAME_W-1:0] top_frame;

    logic               r_in_valid;
    logic               r_in_kind;
    logic [VA_W-1:0]    r_in_vaddr;
    logic [DATA_W-1:0]  r_in_mem;

    t_walk_state        r_state;
    t_walk_state        n_state;
    t_step_res          step_res;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [PA_W-1:0]    r_out_addr;
    logic [STATUS_W-1:0] r_out_status;

    logic               in_fire;
    logic               out_free;
    logic               advance;

    ptw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_top_frame (top_frame)
    );

    ptw_next_step u_step (
        .i_kind      (r_in_kind),
        .i_req_va    (r_in_vaddr),
        .i_mem_data  (r_in_mem),
        .i_top_frame (top_frame),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res       (step_res)
    );

    // Handshake: the input register drains whenever the result slot is free
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= step_res.valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture an accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_kind  <= s_axis_tuser;
            r_in_vaddr <= s_axis_tdata[VA_W-1:0];
            r_in_mem   <= s_axis_tdata[VA_W+DATA_W-1:VA_W];
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (advance && step_res.valid) begin
            r_out_kind   <= step_res.kind;
            r_out_addr   <= step_res.addr;
            r_out_status <= step_res.status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {2'b00, r_out_status, r_out_addr};

    // Walk level stays at idle or within the four table levels
    `PTW_ASSERT_NOW(a_level_range, 1'b1, r_state.level <= LVL_PML4)

    // Entry read requests always carry an ok status
    `PTW_ASSERT_NOW(a_read_status, m_axis_tvalid && m_axis_tuser == RES_READ, m_axis_tdata[53:52] == ST_OK_4K)

    // Faults report a zero address
    `PTW_ASSERT_NOW(a_fault_addr, m_axis_tvalid && (m_axis_tdata[53:52] == ST_NOT_PRESENT || m_axis_tdata[53:52] == ST_UNSUPPORTED), m_axis_tdata[51:0] == '0)

    // A processed request arms the top level of the walk
    `PTW_ASSERT_NEXT(a_req_arms, advance && r_in_kind == KIND_REQUEST, r_state.level == LVL_PML4 && r_out_valid)

endmodule

// ===== hw/rtl/ptw_cfg_regs.sv =====
// APB register block of the page table walker: holds the top-level table frame.
// Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ptw_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ptw_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [ptw_pkg::FRAME_W-1:0]    o_top_frame
);
    import ptw_pkg::*;

    logic [FRAME_W-1:0] r_top_frame;
    logic [FRAME_W-1:0] n_top_frame;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[3] == REG_TOP_FRAME);

    // Take the low 40 bits of a write to the frame register
    always_comb begin
        n_top_frame = r_top_frame;
        if (wr_hit) begin
            n_top_frame = pwdata[FRAME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_frame <= '0;
        end else begin
            r_top_frame <= n_top_frame;
        end
    end

    // Read back: unmapped slots read zero
    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_TOP_FRAME) begin
            prdata = {{(APB_DATA_W-FRAME_W){1'b0}}, r_top_frame};
        end
    end

    assign o_top_frame = r_top_frame;

endmodule

// ===== hw/rtl/ptw_next_step.sv =====
// Combinational step of the page table walker: one item in, next walk state
// and at most one result out. Depends on ptw_pkg.
`timescale 1ns / 1ps

module ptw_next_step (
    input  logic                        i_kind,
    input  logic [ptw_pkg::VA_W-1:0]    i_req_va,
    input  logic [ptw_pkg::DATA_W-1:0]  i_mem_data,
    input  logic [ptw_pkg::FRAME_W-1:0] i_top_frame,
    input  ptw_pkg::t_walk_state        i_state,
    output ptw_pkg::t_walk_state        o_state,
    output ptw_pkg::t_step_res          o_res
);
    import ptw_pkg::*;

    logic [LVL_W-1:0] lower_lvl;
    logic             present;
    logic             big_page;

    assign lower_lvl = i_state.level - 3'd1;
    assign present   = i_mem_data[ENTRY_PRESENT_BIT];
    assign big_page  = i_mem_data[ENTRY_PS_BIT];

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        if (i_kind == KIND_REQUEST) begin
            // Start a new walk, dropping any walk in flight
            o_state.vaddr = i_req_va;
            o_state.level = LVL_PML4;
            o_res.valid   = 1'b1;
            o_res.kind    = RES_READ;
            o_res.addr    = {i_top_frame, level_index(i_req_va, LVL_PML4),
                             {ENTRY_SH_W{1'b0}}};
            o_res.status  = ST_OK_4K;
        end else if (i_state.level == LVL_IDLE || i_state.level > LVL_PML4) begin
            // Stray response: drop it
            o_res.valid = 1'b0;
        end else if (i_state.level == LVL_PT) begin
            // Last level: present bit is not checked
            o_state.level = LVL_IDLE;
            o_res.valid   = 1'b1;
            o_res.kind    = RES_DONE;
            o_res.addr    = {i_mem_data[PA_W-1:PAGE_OFS_W],
                             i_state.vaddr[PAGE_OFS_W-1:0]};
            o_res.status  = ST_OK_4K;
        end else if (!present) begin
            o_state.level = LVL_IDLE;
            o_res.valid   = 1'b1;
            o_res.kind    = RES_DONE;
            o_res.status  = ST_NOT_PRESENT;
        end else if (i_state.level == LVL_PDPT && big_page) begin
            o_state.level = LVL_IDLE;
            o_res.valid   = 1'b1;
            o_res.kind    = RES_DONE;
            o_res.status  = ST_UNSUPPORTED;
        end else if (i_state.level == LVL_PD && big_page) begin
            // 2 MB page ends the walk one level early
            o_state.level = LVL_IDLE;
            o_res.valid   = 1'b1;
            o_res.kind    = RES_DONE;
            o_res.addr    = {i_mem_data[PA_W-1:BIG_OFS_W],
                             i_state.vaddr[BIG_OFS_W-1:0]};
            o_res.status  = ST_OK_2M;
        end else begin
            // Descend one level and request its entry
            o_state.level = lower_lvl;
            o_res.valid   = 1'b1;
            o_res.kind    = RES_READ;
            o_res.addr    = {i_mem_data[PA_W-1:PAGE_OFS_W],
                             level_index(i_state.vaddr, lower_lvl),
                             {ENTRY_SH_W{1'b0}}};
            o_res.status  = ST_OK_4K;
        end
    end

endmodule
